// ===== hdl/bpfa_pkg.sv =====
package bpfa_pkg;

  // Sizing of the frame pool and of the per-process page table
  localparam int NUM_FRAMES = 8;
  localparam int MAX_PAGES  = 8;

  localparam int FRAME_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PAGE_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int FREE_W   = $clog2(NUM_FRAMES + 1);
  localparam int CNT_W    = $clog2(MAX_PAGES + 1);
  localparam int NPAGES_W = 4;
  localparam int CMP_W    = 8;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FRAMES    = 2'd1,
    ST_NOTHING_FREE = 2'd2,
    ST_TOO_LARGE    = 2'd3
  } status_t;

  // Result of the lowest-free-frame search
  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
  } ffs_t;

endpackage

// ===== hdl/bpfa_if.sv =====
interface bpfa_req_if import bpfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [NPAGES_W-1:0] num_pages;

  modport source (output valid, command, num_pages, input ready);
  modport sink   (input valid, command, num_pages, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic               page_valid;
  logic [PAGE_W-1:0]  page_index;
  logic [FRAME_W-1:0] frame_number;
  logic [FREE_W-1:0]  free_frames;
  logic               last;

  modport source (output valid, status, page_valid, page_index, frame_number,
                  free_frames, last, input ready);
  modport sink   (input valid, status, page_valid, page_index, frame_number,
                  free_frames, last, output ready);
endinterface

// ===== hdl/bpfa_first_free.sv =====
module bpfa_first_free import bpfa_pkg::*; (
  input  logic [NUM_FRAMES-1:0] used_map,
  output ffs_t                  ffs
);

  // priority encoder: lowest clear bit wins
  always_comb begin
    ffs = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!used_map[i]) begin
        ffs.found = 1'b1;
        ffs.frame = FRAME_W'(i);
      end
    end
  end

endmodule

// ===== hdl/bpfa_core.sv =====
module bpfa_core import bpfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bpfa_req_if.sink              in_req,
  bpfa_rsp_if.source            out_rsp,
  output logic [NUM_FRAMES-1:0] used_map,
  input  ffs_t                  ffs
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE
  } state_t;

  state_t                state_r, state_nxt;
  logic [NUM_FRAMES-1:0] frame_used_r, frame_used_nxt;
  logic [FREE_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  alloc_r, alloc_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;

  logic                  ovalid_r, ovalid_nxt;
  status_t               ostatus_r, ostatus_nxt;
  logic                  opv_r, opv_nxt;
  logic [PAGE_W-1:0]     opage_r, opage_nxt;
  logic [FRAME_W-1:0]    oframe_r, oframe_nxt;
  logic [FREE_W-1:0]     ofree_r, ofree_nxt;
  logic                  olast_r, olast_nxt;

  logic [FRAME_W-1:0]    tbl_r [MAX_PAGES];
  logic                  tbl_we;
  logic [PAGE_W-1:0]     tbl_idx;
  logic [FRAME_W-1:0]    rel_frame;
  logic                  slot_free;
  logic                  accept;
  logic                  alloc_last;

  assign slot_free    = !ovalid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE) && slot_free;
  assign accept       = in_req.valid && in_req.ready;
  assign used_map     = frame_used_r;
  assign tbl_idx      = idx_r[PAGE_W-1:0];
  assign rel_frame    = tbl_r[tbl_idx];
  assign alloc_last   = (idx_r + 1'b1) == count_r;

  assign out_rsp.valid        = ovalid_r;
  assign out_rsp.status       = ostatus_r;
  assign out_rsp.page_valid   = opv_r;
  assign out_rsp.page_index   = opage_r;
  assign out_rsp.frame_number = oframe_r;
  assign out_rsp.free_frames  = ofree_r;
  assign out_rsp.last         = olast_r;

  always_comb begin
    state_nxt      = state_r;
    frame_used_nxt = frame_used_r;
    free_cnt_nxt   = free_cnt_r;
    count_nxt      = count_r;
    alloc_nxt      = alloc_r;
    idx_nxt        = idx_r;
    ovalid_nxt     = ovalid_r && !out_rsp.ready;
    ostatus_nxt    = ostatus_r;
    opv_nxt        = opv_r;
    opage_nxt      = opage_r;
    oframe_nxt     = oframe_r;
    ofree_nxt      = ofree_r;
    olast_nxt      = olast_r;
    tbl_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // single-result replies carry no page
          opv_nxt    = 1'b0;
          opage_nxt  = '0;
          oframe_nxt = '0;
          ofree_nxt  = free_cnt_r;
          olast_nxt  = 1'b1;
          idx_nxt    = '0;
          if (in_req.command == CMD_FREE) begin
            if (!alloc_r) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_NOTHING_FREE;
            end else begin
              state_nxt = S_FREE;
            end
          end else if (CMP_W'(in_req.num_pages) > CMP_W'(MAX_PAGES)) begin
            ovalid_nxt  = 1'b1;
            ostatus_nxt = ST_TOO_LARGE;
          end else if (CMP_W'(in_req.num_pages) > CMP_W'(free_cnt_r)) begin
            ovalid_nxt  = 1'b1;
            ostatus_nxt = ST_NO_FRAMES;
          end else begin
            count_nxt = CNT_W'(in_req.num_pages);
            alloc_nxt = 1'b1;
            if (in_req.num_pages == '0) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_OK;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
        end
      end
      S_ALLOC: begin
        if (slot_free) begin
          frame_used_nxt[ffs.frame] = 1'b1;
          free_cnt_nxt = free_cnt_r - 1'b1;
          tbl_we       = 1'b1;
          ovalid_nxt   = 1'b1;
          ostatus_nxt  = ST_OK;
          opv_nxt      = 1'b1;
          opage_nxt    = tbl_idx;
          oframe_nxt   = ffs.frame;
          ofree_nxt    = free_cnt_r - 1'b1;
          olast_nxt    = alloc_last;
          idx_nxt      = idx_r + 1'b1;
          if (alloc_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FREE: begin
        if (idx_r < count_r) begin
          if (frame_used_r[rel_frame]) begin
            frame_used_nxt[rel_frame] = 1'b0;
            free_cnt_nxt = free_cnt_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end else if (slot_free) begin
          alloc_nxt   = 1'b0;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          ofree_nxt   = free_cnt_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_used_r <= '0;
      free_cnt_r   <= FREE_W'(NUM_FRAMES);
      count_r      <= '0;
      alloc_r      <= 1'b0;
      idx_r        <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_used_r <= frame_used_nxt;
      free_cnt_r   <= free_cnt_nxt;
      count_r      <= count_nxt;
      alloc_r      <= alloc_nxt;
      idx_r        <= idx_nxt;
      ovalid_r     <= ovalid_nxt;
    end
    ostatus_r <= ostatus_nxt;
    opv_r     <= opv_nxt;
    opage_r   <= opage_nxt;
    oframe_r  <= oframe_nxt;
    ofree_r   <= ofree_nxt;
    olast_r   <= olast_nxt;
  end

  // page table: no reset, entries read only below the recorded count
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[tbl_idx] <= ffs.frame;
    end
  end

  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r == FREE_W'(NUM_FRAMES - $countones(frame_used_r)))
    else $error("free count out of step with bitmap");

  a_alloc_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> ffs.found)
    else $error("allocation running with no free frame");

  a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && slot_free) |=> free_cnt_r == $past(free_cnt_r) - 1'b1)
    else $error("granted page did not consume a frame");

endmodule

// ===== hdl/bitmap_page_frame_allocator.sv =====
// Allocate of N pages: after the request is accepted, one page per cycle while
// the result slot can take it (the shared first-free encoder grants one frame a
// cycle). Error and zero-page replies are a single result. Free: the request is
// accepted, each table entry is walked, then the reply is given. Backpressure
// on the result side holds back the page results and the replies.
// Reset (synchronous, active low): all frames free, none allocated, table kept.
module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bpfa_req_if.sink   in_req,
  bpfa_rsp_if.source out_rsp
);

  // Reset leaves the page table unwritten; it is only read below the count
  // recorded by the last allocate.

  // bitmap of used frames, owned by the sequencer
  logic [NUM_FRAMES-1:0] used_map;
  // lowest free frame, recomputed every cycle from the bitmap
  ffs_t                  ffs;

  // Shared search unit: one grant per cycle while allocating and the slot is free
  bpfa_first_free u_first_free (
    .used_map (used_map),
    .ffs      (ffs)
  );

  // Sequencer: request checks, page grant loop, release walk over the table,
  // and the registered result slot that decouples the response side.
  bpfa_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .used_map (used_map),
    .ffs      (ffs)
  );

endmodule

// ===== bench/bpfa_tb_pkg.sv =====
package bpfa_tb_pkg;
  import bpfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One reply beat as seen on the result channel
  typedef struct packed {
    status_t            status;
    logic               page_valid;
    logic [PAGE_W-1:0]  page_index;
    logic [FRAME_W-1:0] frame_number;
    logic [FREE_W-1:0]  free_frames;
    logic               last;
  } grant_t;

  // Tracks the frame bitmap and page table, queues the replies due
  class frame_alloc_scoreboard;
    logic [NUM_FRAMES-1:0] used_map;
    logic [FRAME_W-1:0]    page_frame [MAX_PAGES];
    int unsigned           mapped_pages;
    bit                    holds_table;
    grant_t                pending_grants [$];
    int unsigned           failures;

    function new();
      used_map     = '0;
      mapped_pages = 0;
      holds_table  = 1'b0;
      failures     = 0;
      foreach (page_frame[i]) page_frame[i] = '0;
    endfunction

    function int unsigned free_count();
      int unsigned n;
      n = 0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (!used_map[i]) n++;
      end
      return n;
    endfunction

    function void push_grant(status_t st, logic pv, int page, int frame, logic fin);
      grant_t g;
      g.status       = st;
      g.page_valid   = pv;
      g.page_index   = PAGE_W'(page);
      g.frame_number = FRAME_W'(frame);
      g.free_frames  = FREE_W'(free_count());
      g.last         = fin;
      pending_grants.push_back(g);
    endfunction

    // Called for every accepted request
    function void note_request(cmd_t cmd, logic [NPAGES_W-1:0] n);
      int j;
      if (cmd == CMD_FREE) begin
        if (!holds_table) begin
          push_grant(ST_NOTHING_FREE, 1'b0, 0, 0, 1'b1);
          return;
        end
        for (int i = 0; i < mapped_pages; i++) used_map[page_frame[i]] = 1'b0;
        holds_table = 1'b0;
        push_grant(ST_OK, 1'b0, 0, 0, 1'b1);
        return;
      end
      if (n > MAX_PAGES) begin
        push_grant(ST_TOO_LARGE, 1'b0, 0, 0, 1'b1);
        return;
      end
      if (n > free_count()) begin
        push_grant(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
        return;
      end
      // earlier table (if any) is simply overwritten, its frames stay used
      mapped_pages = n;
      holds_table  = 1'b1;
      if (n == 0) begin
        push_grant(ST_OK, 1'b0, 0, 0, 1'b1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        for (j = 0; j < NUM_FRAMES; j++) begin
          if (!used_map[j]) break;
        end
        used_map[j]   = 1'b1;
        page_frame[i] = FRAME_W'(j);
        push_grant(ST_OK, 1'b1, i, j, (i + 1 == n));
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    // Called for every accepted reply beat
    function void check_result(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        failures++;
        $display("%0t: unexpected reply, expected none actual status %0d frame %0d",
                 $time, got.status, got.frame_number);
        return;
      end
      want = pending_grants.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("page_valid", want.page_valid, got.page_valid);
      compare_field("page_index", want.page_index, got.page_index);
      compare_field("frame_number", want.frame_number, got.frame_number);
      compare_field("free_frames", want.free_frames, got.free_frames);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

// ===== bench/bitmap_page_frame_allocator_tb.sv =====
module bitmap_page_frame_allocator_tb import bpfa_pkg::*, bpfa_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles tolerated before the run is abandoned. A free walks at most
  // MAX_PAGES entries, so even with reply stalls this is generous.
  localparam int WATCHDOG_LIMIT = 1000;
  // Settling time after the last reply has been seen
  localparam int DRAIN_CYCLES   = 20;
  // Request count at which the well-formed random phase stops
  localparam int RANDOM_END     = 235;
  // Requests in the closing phase, where frames get leaked for good
  localparam int LEAK_REQUESTS  = 45;

  logic clk;
  logic rst_n;
  bit   steady_run;        // when set neither side inserts idle cycles
  int   requests_sent;
  int   quiet_cycles;

  bpfa_req_if req_ch ();
  bpfa_rsp_if rsp_ch ();

  frame_alloc_scoreboard grants = new();

  bitmap_page_frame_allocator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Request side. Inputs only ever change on the falling edge; acceptance is
  // judged on the rising edge from the pre-edge values of valid and ready.
  // valid is left high between back-to-back requests and only dropped on a
  // gap, so it never toggles twice within one time step.
  // ------------------------------------------------------------------------
  task automatic send_request(cmd_t cmd, logic [NPAGES_W-1:0] n);
    while (!steady_run && $urandom_range(99) < 12) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.command   = cmd;
    req_ch.num_pages = n;
    do @(posedge clk); while (!req_ch.ready);
    grants.note_request(cmd, n);
    requests_sent++;
  endtask

  // Hold off the sender until every reply owed has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (grants.pending_grants.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Reply side: ready drops at random, about 12 percent of the time, never during the
  // steady stretch.
  // ------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = steady_run || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    grant_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.status       = rsp_ch.status;
      got.page_valid   = rsp_ch.page_valid;
      got.page_index   = rsp_ch.page_index;
      got.frame_number = rsp_ch.frame_number;
      got.free_frames  = rsp_ch.free_frames;
      got.last         = rsp_ch.last;
      grants.check_result(got);
    end
  end

  // Watchdog: any handshake on either channel counts as progress
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int pages;
    int round;

    rst_n            = 1'b0;
    steady_run       = 1'b0;
    requests_sent    = 0;
    round            = 0;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_ALLOC;
    req_ch.num_pages = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed part --------------------------------------------------
    send_request(CMD_FREE, 4'd15);   // nothing held yet: nothing to free
    send_request(CMD_ALLOC, 4'd0);   // zero pages: no page, table now held
    send_request(CMD_FREE, 4'd0);    // frees an empty table
    send_request(CMD_FREE, 4'd0);    // free twice: nothing to free
    send_request(CMD_ALLOC, 4'd9);   // just over the table size
    send_request(CMD_ALLOC, 4'd15);  // far over the table size
    send_request(CMD_ALLOC, 4'd8);   // every frame, 0 up to 7
    send_request(CMD_ALLOC, 4'd1);   // pool exhausted: not enough frames
    send_request(CMD_ALLOC, 4'd15);  // size check wins over the frame check
    send_request(CMD_FREE, 4'd8);
    send_request(CMD_ALLOC, 4'd1);
    send_request(CMD_FREE, 4'd7);
    send_request(CMD_ALLOC, 4'd0);
    send_request(CMD_ALLOC, 4'd5);   // second allocate over a held (empty) table
    send_request(CMD_ALLOC, 4'd6);   // only 3 left: not enough frames
    send_request(CMD_FREE, 4'd3);
    send_request(CMD_ALLOC, 4'd7);
    send_request(CMD_FREE, 4'd12);
    send_request(CMD_ALLOC, 4'd8);
    send_request(CMD_FREE, 4'd1);

    // sender sits still until the block has answered everything
    wait_drained();

    // --- random part: allocate / refused requests / free ----------------
    // A second allocate on a held table leaks frames for the rest of the
    // run, so this phase only issues requests that are refused while a
    // table is held; the leaking cases come last.
    while (requests_sent < RANDOM_END) begin
      steady_run = (round >= 30 && round < 45);
      round++;
      if ($urandom_range(99) < 80) begin
        pages = ($urandom_range(5) == 0) ? MAX_PAGES : $urandom_range(MAX_PAGES);
        send_request(CMD_ALLOC, NPAGES_W'(pages));
        repeat ($urandom_range(2)) begin
          // more than is left, or over the table size: changes nothing
          send_request(CMD_ALLOC, NPAGES_W'($urandom_range(15, NUM_FRAMES + 1 - pages)));
        end
        send_request(CMD_FREE, NPAGES_W'($urandom()));
        if ($urandom_range(3) == 0) send_request(CMD_FREE, NPAGES_W'($urandom()));
      end else if ($urandom_range(1) == 0) begin
        send_request(CMD_FREE, NPAGES_W'($urandom()));
      end else begin
        send_request(CMD_ALLOC, NPAGES_W'($urandom_range(15, MAX_PAGES + 1)));
      end
    end
    steady_run = 1'b0;

    wait_drained();

    // --- closing phase: anything goes, frames lost to re-allocation -----
    repeat (LEAK_REQUESTS) begin
      if ($urandom_range(99) < 35) begin
        send_request(CMD_FREE, NPAGES_W'($urandom()));
      end else if ($urandom_range(9) == 0) begin
        send_request(CMD_ALLOC, NPAGES_W'($urandom_range(15)));
      end else begin
        send_request(CMD_ALLOC, NPAGES_W'($urandom_range(4)));
      end
    end

    // --- wind down ------------------------------------------------------
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (grants.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (grants.failures == 0 && grants.pending_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bpfa_pkg.sv
hdl/bpfa_if.sv
hdl/bpfa_first_free.sv
hdl/bpfa_core.sv
hdl/bitmap_page_frame_allocator.sv
bench/bpfa_tb_pkg.sv
bench/bitmap_page_frame_allocator_tb.sv
